// File: hdl/frm_pkg.sv
// ----------------------------------------------------------------------------
// Frame rate meter package
// Shared widths, constants, sequencer codes and divider status type.
// ----------------------------------------------------------------------------
package frm_pkg;

    localparam int DATA_W = 24;

    localparam logic [DATA_W-1:0] RATE_NUM = 24'd16000000;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_READ     = 6'b000010,
        ST_DIV_INST = 6'b000100,
        ST_DIV_MEAN = 6'b001000,
        ST_DIV_RATE = 6'b010000,
        ST_OUT      = 6'b100000
    } frm_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } frm_div_status_t;

endpackage

// File: hdl/frm_ring.sv
// ----------------------------------------------------------------------------
// Frame rate meter duration ring
// Single write port, single registered read port sample memory.
// ----------------------------------------------------------------------------
module frm_ring
    import frm_pkg::*;
#(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/frm_div.sv
// ----------------------------------------------------------------------------
// Frame rate meter divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module frm_div
    import frm_pkg::*;
#(
    parameter int W = 31
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic [W-1:0]    dividend,
    input  logic [W-1:0]    divisor,
    output logic [W-1:0]    quotient,
    output frm_div_status_t status
);

    localparam int CW = $clog2(W);

    logic          busy_reg;
    logic          busy_next;
    logic          done_reg;
    logic          done_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  rem_next;
    logic [W-1:0]  quo_reg;
    logic [W-1:0]  quo_next;
    logic [W-1:0]  dsr_reg;
    logic [W-1:0]  dsr_next;
    logic [W:0]    shifted;
    logic [W+1:0]  trial;

    always_comb begin
        shifted   = {rem_reg, quo_reg[W-1]};
        trial     = {1'b0, shifted} - {2'b00, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            if (trial[W+1]) begin
                rem_next = shifted[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end else begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(W-1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// File: hdl/frame_rate_meter.sv
// ----------------------------------------------------------------------------
// Frame rate meter
// Instant and windowed mean frame duration and rate from frame events.
// ----------------------------------------------------------------------------
// Each request carries one frame duration in microseconds and returns one
// result: the duration clamped to at least 1 us, the instant rate
// 16000000/duration in 1/16 fps, the held window mean duration and rate, and
// a window-full flag. All arithmetic goes through one shared restoring divider
// of DIV_W = 24 + clog2(SAMPLES+1) bits that yields one quotient bit a cycle.
// A request takes one division while the window is not full or holds only zero
// entries, and three otherwise (two more divisions for the mean). The sample
// ring needs no clearing pass: it is filled in order, and until the window is
// full the sample being replaced is taken as zero.
// ----------------------------------------------------------------------------
module frame_rate_meter
    import frm_pkg::*;
#(
    parameter int SAMPLES = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [DATA_W-1:0] s_frame_time_us,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [DATA_W-1:0] m_instant_duration_us,
    output logic [DATA_W-1:0] m_instant_rate_q4,
    output logic [DATA_W-1:0] m_mean_duration_us,
    output logic [DATA_W-1:0] m_mean_rate_q4,
    output logic              m_window_full
);

    localparam int SLOT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int CNT_W  = $clog2(SAMPLES + 1);
    localparam int DIV_W  = DATA_W + CNT_W;

    frm_state_t        state_reg;
    frm_state_t        state_next;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic [CNT_W-1:0]  frames_reg;
    logic [CNT_W-1:0]  frames_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [DIV_W-1:0]  sum_reg;
    logic [DIV_W-1:0]  sum_next;
    logic [DATA_W-1:0] mean_reg;
    logic [DATA_W-1:0] mean_next;
    logic [DATA_W-1:0] mean_rate_reg;
    logic [DATA_W-1:0] mean_rate_next;
    logic [DATA_W-1:0] raw_reg;
    logic [DATA_W-1:0] raw_next;
    logic [DATA_W-1:0] inst_rate_reg;
    logic [DATA_W-1:0] inst_rate_next;
    logic              m_valid_reg;
    logic              m_valid_next;
    logic [DATA_W-1:0] out_dur_reg;
    logic [DATA_W-1:0] out_rate_reg;
    logic [DATA_W-1:0] out_mean_reg;
    logic [DATA_W-1:0] out_mean_rate_reg;
    logic              out_full_reg;

    logic              accept;
    logic              load_out;
    logic              full_now;
    logic [DATA_W-1:0] dur;
    logic [DATA_W-1:0] old_dur;
    logic [DATA_W-1:0] ring_rdata;
    logic              ring_we;

    logic              div_start;
    logic [DIV_W-1:0]  div_dividend;
    logic [DIV_W-1:0]  div_divisor;
    logic [DIV_W-1:0]  div_quo;
    frm_div_status_t   div_st;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign full_now = (frames_reg == CNT_W'(SAMPLES));
    assign dur      = (raw_reg == '0) ? DATA_W'(1) : raw_reg;
    assign old_dur  = full_now ? ring_rdata : '0;
    assign load_out = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
    assign ring_we  = (state_reg == ST_READ);

    frm_ring #(
        .DEPTH  (SAMPLES),
        .ADDR_W (SLOT_W)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ring_we),
        .wr_addr (slot_reg),
        .wr_data (raw_reg),
        .rd_en   (accept),
        .rd_addr (slot_reg),
        .rd_data (ring_rdata)
    );

    frm_div #(
        .W (DIV_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quo),
        .status   (div_st)
    );

    always_comb begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        frames_next    = frames_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        mean_next      = mean_reg;
        mean_rate_next = mean_rate_reg;
        raw_next       = raw_reg;
        inst_rate_next = inst_rate_reg;
        div_start      = 1'b0;
        div_dividend   = DIV_W'(RATE_NUM);
        div_divisor    = DIV_W'(dur);
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    raw_next   = s_frame_time_us;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                sum_next   = sum_reg - DIV_W'(old_dur) + DIV_W'(raw_reg);
                count_next = count_reg - CNT_W'(old_dur != '0) + CNT_W'(raw_reg != '0);
                if (!full_now) begin
                    frames_next = frames_reg + 1'b1;
                end
                slot_next  = (slot_reg == SLOT_W'(SAMPLES - 1)) ? '0 : slot_reg + 1'b1;
                div_start  = 1'b1;
                state_next = ST_DIV_INST;
            end
            ST_DIV_INST: begin
                div_dividend = sum_reg;
                div_divisor  = DIV_W'(count_reg);
                if (div_st.done) begin
                    inst_rate_next = div_quo[DATA_W-1:0];
                    if (full_now && (count_reg != '0)) begin
                        div_start  = 1'b1;
                        state_next = ST_DIV_MEAN;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_DIV_MEAN: begin
                div_divisor = DIV_W'(div_quo[DATA_W-1:0]);
                if (div_st.done) begin
                    mean_next  = div_quo[DATA_W-1:0];
                    div_start  = 1'b1;
                    state_next = ST_DIV_RATE;
                end
            end
            ST_DIV_RATE: begin
                if (div_st.done) begin
                    mean_rate_next = div_quo[DATA_W-1:0];
                    state_next     = ST_OUT;
                end
            end
            ST_OUT: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            slot_reg      <= '0;
            frames_reg    <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            mean_reg      <= '0;
            mean_rate_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            frames_reg    <= frames_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            mean_reg      <= mean_next;
            mean_rate_reg <= mean_rate_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        raw_reg       <= raw_next;
        inst_rate_reg <= inst_rate_next;
        if (load_out) begin
            out_dur_reg       <= dur;
            out_rate_reg      <= inst_rate_reg;
            out_mean_reg      <= mean_reg;
            out_mean_rate_reg <= mean_rate_reg;
            out_full_reg      <= full_now;
        end
    end

    assign m_valid               = m_valid_reg;
    assign m_instant_duration_us = out_dur_reg;
    assign m_instant_rate_q4     = out_rate_reg;
    assign m_mean_duration_us    = out_mean_reg;
    assign m_mean_rate_q4        = out_mean_rate_reg;
    assign m_window_full         = out_full_reg;

    a_count_le_frames: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= frames_reg)
        else $error("nonzero count exceeds frames seen");

    a_slot_tracks_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        !full_now |-> (CNT_W'(slot_reg) == frames_reg))
        else $error("write slot out of step with fill count");

    a_done_in_div_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_st.done |-> (state_reg == ST_DIV_INST || state_reg == ST_DIV_MEAN
                         || state_reg == ST_DIV_RATE))
        else $error("divider finished outside a divide step");

    a_no_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_st.busy)
        else $error("divider restarted while busy");

endmodule

// File: tb/sv/frame_rate_meter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame rate meter testbench
// Drives frame durations through the meter and checks each result against a
// running model of the sample ring, instant rate and held window mean.
// ----------------------------------------------------------------------------
// A short directed pass covers zero, one, full-scale and rate-boundary
// durations. It is followed by random segments: video-like jittered periods,
// full-range values, corner values and long zero runs that empty the window.
// Both handshakes idle at random, and once the receiver holds off for a long
// stretch so that the meter backs up into its input.
// ----------------------------------------------------------------------------
module frame_rate_meter_tb;
    import frm_pkg::*;

    localparam int SAMPLES        = 64;
    localparam int RANDOM_ITEMS   = 850;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 250;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int DIRECTED_ITEMS = 20;
    localparam logic [DATA_W-1:0] FULL_SCALE = {DATA_W{1'b1}};

    typedef struct packed {
        logic [DATA_W-1:0] inst_us;
        logic [DATA_W-1:0] inst_rate;
        logic [DATA_W-1:0] mean_us;
        logic [DATA_W-1:0] mean_rate;
        logic              full;
    } meter_result_t;

    typedef enum int {
        MIX_VIDEO,
        MIX_WIDE,
        MIX_CORNER,
        MIX_ZERO
    } traffic_kind_t;

    class frame_meter_tracker;
        logic [DATA_W-1:0] ring_slots [SAMPLES];
        logic [5:0]        next_slot;
        logic [6:0]        frame_count;
        logic [29:0]       slot_total;
        logic [6:0]        live_slots;
        logic [DATA_W-1:0] mean_us;
        logic [DATA_W-1:0] mean_rate;
        meter_result_t     pending_results [$];
        int                errors;
        int                matched;
        int                full_results;
        int                empty_window_holds;

        function new();
            for (int i = 0; i < SAMPLES; i++) ring_slots[i] = '0;
            next_slot          = '0;
            frame_count        = '0;
            slot_total         = '0;
            live_slots         = '0;
            mean_us            = '0;
            mean_rate          = '0;
            errors             = 0;
            matched            = 0;
            full_results       = 0;
            empty_window_holds = 0;
        endfunction

        function void log_request(logic [DATA_W-1:0] raw);
            meter_result_t     r;
            logic [DATA_W-1:0] old;
            logic [DATA_W-1:0] dur;
            logic [29:0]       avg;
            if (frame_count < SAMPLES) frame_count++;
            old = ring_slots[next_slot];
            slot_total = slot_total - {6'd0, old} + {6'd0, raw};
            if (old != 0) live_slots--;
            if (raw != 0) live_slots++;
            ring_slots[next_slot] = raw;
            next_slot = (next_slot == SAMPLES - 1) ? 6'd0 : next_slot + 6'd1;
            dur = (raw == 0) ? 24'd1 : raw;
            r.full = (frame_count >= SAMPLES);
            if (r.full && live_slots != 0) begin
                avg = slot_total / {23'd0, live_slots};
                if (avg < 1) avg = 30'd1;
                if (avg > {6'd0, FULL_SCALE}) avg = {6'd0, FULL_SCALE};
                mean_us   = avg[DATA_W-1:0];
                mean_rate = RATE_NUM / mean_us;
            end else if (r.full) begin
                empty_window_holds++;
            end
            r.inst_us   = dur;
            r.inst_rate = RATE_NUM / dur;
            r.mean_us   = mean_us;
            r.mean_rate = mean_rate;
            pending_results.push_back(r);
        endfunction

        function void match_result(meter_result_t got);
            meter_result_t want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result inst_us=%0d rate=%0d", $time,
                         got.inst_us, got.inst_rate);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            matched++;
            if (want.full) full_results++;
            if (got.inst_us !== want.inst_us) begin
                $display("%0t: instant_duration_us expected %0d actual %0d", $time,
                         want.inst_us, got.inst_us);
                errors++;
            end
            if (got.inst_rate !== want.inst_rate) begin
                $display("%0t: instant_rate_q4 expected %0d actual %0d", $time,
                         want.inst_rate, got.inst_rate);
                errors++;
            end
            if (got.mean_us !== want.mean_us) begin
                $display("%0t: mean_duration_us expected %0d actual %0d", $time,
                         want.mean_us, got.mean_us);
                errors++;
            end
            if (got.mean_rate !== want.mean_rate) begin
                $display("%0t: mean_rate_q4 expected %0d actual %0d", $time,
                         want.mean_rate, got.mean_rate);
                errors++;
            end
            if (got.full !== want.full) begin
                $display("%0t: window_full expected %0b actual %0b", $time,
                         want.full, got.full);
                errors++;
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic              aclk                  = 1'b0;
    logic              aresetn               = 1'b0;
    logic              s_valid               = 1'b0;
    logic              s_ready;
    logic [DATA_W-1:0] s_frame_time_us       = '0;
    logic              m_valid;
    logic              m_ready               = 1'b0;
    logic [DATA_W-1:0] m_instant_duration_us;
    logic [DATA_W-1:0] m_instant_rate_q4;
    logic [DATA_W-1:0] m_mean_duration_us;
    logic [DATA_W-1:0] m_mean_rate_q4;
    logic              m_window_full;

    frame_meter_tracker tracker;
    int  accepted        = 0;
    int  burst_left      = 0;
    int  cycle_count     = 0;
    int  input_stalls    = 0;
    bit  hold_rx         = 1'b0;
    int  rx_mode         = 0;
    int  rx_phase_left   = 0;
    int  rx_tick         = 0;

    frame_rate_meter #(
        .SAMPLES(SAMPLES)
    ) dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_frame_time_us      (s_frame_time_us),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_instant_duration_us(m_instant_duration_us),
        .m_instant_rate_q4    (m_instant_rate_q4),
        .m_mean_duration_us   (m_mean_duration_us),
        .m_mean_rate_q4       (m_mean_rate_q4),
        .m_window_full        (m_window_full)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (hold_rx && s_valid && !s_ready) input_stalls++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            tracker.match_result('{m_instant_duration_us, m_instant_rate_q4,
                                   m_mean_duration_us, m_mean_rate_q4, m_window_full});
        end
    end

    // receiver stall pattern: phases of always-ready, random, periodic and sparse
    always @(negedge aclk) begin
        bit rdy;
        if (rx_phase_left == 0) begin
            rx_mode       = $urandom_range(0, 3);
            rx_phase_left = $urandom_range(20, 300);
        end
        rx_phase_left--;
        rx_tick++;
        case (rx_mode)
            0: rdy = 1'b1;
            1: rdy = $urandom_range(0, 1);
            2: rdy = (rx_tick % 4) != 0;
            default: rdy = ($urandom_range(0, 3) == 0);
        endcase
        m_ready <= hold_rx ? 1'b0 : rdy;
    end

    // long receiver hold-off so the meter backs up into its input
    initial begin
        wait (accepted >= 300);
        @(posedge aclk);
        hold_rx = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_rx = 1'b0;
    end

    task automatic offer_request(input logic [DATA_W-1:0] t);
        int gap;
        s_valid         <= 1'b1;
        s_frame_time_us <= t;
        do @(posedge aclk); while (!s_ready);
        tracker.log_request(t);
        accepted++;
        @(negedge aclk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end else begin
            burst_left--;
        end
    endtask

    function automatic logic [DATA_W-1:0] pick_frame_time(traffic_kind_t kind);
        int base;
        case (kind)
            MIX_VIDEO: begin
                case ($urandom_range(0, 4))
                    0: base = 16667;
                    1: base = 33333;
                    2: base = 8333;
                    3: base = 41667;
                    default: base = 6944;
                endcase
                return DATA_W'(base + $urandom_range(0, 400) - 200);
            end
            MIX_WIDE: begin
                if ($urandom_range(0, 3) == 0) return DATA_W'($urandom_range(0, 255));
                return DATA_W'($urandom_range(0, 24'hFFFFFF));
            end
            MIX_CORNER: begin
                case ($urandom_range(0, 7))
                    0: return '0;
                    1: return 24'd1;
                    2: return FULL_SCALE;
                    3: return FULL_SCALE - 24'd1;
                    4: return 24'd16000000;
                    5: return 24'd16000001;
                    6: return 24'd15999999;
                    default: return DATA_W'(1) << $urandom_range(0, DATA_W - 1);
                endcase
            end
            default: return '0;
        endcase
    endfunction

    initial begin
        logic [DATA_W-1:0] directed [DIRECTED_ITEMS];
        traffic_kind_t kind;
        int seg_len;
        int sent;
        directed = '{
            24'd0, 24'd1, FULL_SCALE, FULL_SCALE - 24'd1, 24'd16000000,
            24'd16000001, 24'd15999999, 24'd2, 24'd3, 24'd16, 24'd17,
            24'd16667, 24'd33333, 24'd0, 24'd0, 24'd1000000, 24'd800000,
            24'd123456, 24'hAAAAAA, 24'h555555
        };
        tracker = new();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        foreach (directed[i]) offer_request(directed[i]);
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 19))
                0, 1:       kind = MIX_ZERO;
                2, 3, 4:    kind = MIX_WIDE;
                5, 6, 7:    kind = MIX_CORNER;
                default:    kind = MIX_VIDEO;
            endcase
            seg_len = (kind == MIX_ZERO) ? $urandom_range(SAMPLES, SAMPLES + 8)
                                         : $urandom_range(8, 60);
            for (int k = 0; k < seg_len; k++) begin
                offer_request(pick_frame_time(kind));
                sent++;
            end
        end
        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("covered %0d frame requests, %0d results checked, %0d with a full window",
                 accepted, tracker.matched, tracker.full_results);
        $display("means held over an all-zero window %0d times, input stalled %0d cycles",
                 tracker.empty_window_holds, input_stalls);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
